>>> hw/rtl/mcant_pkg.sv
package mcant_pkg;

  localparam int unsigned GRID_COLS_DEF  = 256;
  localparam int unsigned GRID_ROWS_DEF  = 256;
  localparam int unsigned NUM_SHADES_DEF = 256;

  // largest grid dimension the 8-bit coordinates can address
  localparam int unsigned SHADE_SPACE = 256;

  localparam int unsigned DIM_W     = 9;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned SHADE_W   = 8;
  localparam int unsigned TURN_W    = 2;
  localparam int unsigned GEN_W     = 48;
  localparam int unsigned RULE_W    = SHADE_W + TURN_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TURN_W-1:0] TURN_BAD = 2'd3;

  typedef enum logic [1:0] {
    CMD_WRITE_RULE = 2'd0,
    CMD_WRITE_CELL = 2'd1,
    CMD_PLACE      = 2'd2,
    CMD_STEP       = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_MOVED    = 3'd0,
    ST_BOUNDARY = 3'd1,
    ST_HALTED   = 3'd2,
    ST_NO_RULE  = 3'd3,
    ST_ACK      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    HEAD_NORTH = 2'd0,
    HEAD_EAST  = 2'd1,
    HEAD_SOUTH = 2'd2,
    HEAD_WEST  = 2'd3
  } heading_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [SHADE_W-1:0] shade;
    logic [SHADE_W-1:0] replacement;
    logic [TURN_W-1:0]  turn;
    heading_e           heading;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   ant_row;
    logic [POS_W-1:0]   ant_col;
    heading_e           ant_heading;
    logic [SHADE_W-1:0] new_shade;
    logic [GEN_W-1:0]   generation;
  } out_word_t;

endpackage

>>> hw/rtl/mcant_ram.sv
module mcant_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/multicolor_ant_automaton_step_unit.sv
// Multi-shade ant automaton on a bounded grid.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one command word:
// write rule, write cell, place ant or step. Every word gives exactly one
// result word on the output channel (out_valid_o/out_ready_i, out_data_o).
// Config channel (cfg_*) sets grid width and height; always ready, write
// only while no command is in flight.
// Write rule, write cell, place and a refused step (halted) finish at the
// accept edge: result visible the next cycle, one word per cycle while the
// output buffer has room. A live step runs grid RAM read, rule RAM read,
// then update and cell write-back; in_ready_o stays low while step_b_q or
// step_c_q is set because the next step needs the updated ant position.
// Results go into a two-word output buffer, so one more command is taken
// while a result waits; with both words waiting in_ready_o drops.
// Reset clears the ant (row 0, column 0, north), the halt flag, the
// generation count, all rule valid bits and sets the grid to 256 x 256.
// Grid and rule RAMs are not cleared; a never-written cell reads as junk.
module multicolor_ant_automaton_step_unit #(
  parameter int unsigned GRID_COLS  = mcant_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS  = mcant_pkg::GRID_ROWS_DEF,
  parameter int unsigned NUM_SHADES = mcant_pkg::NUM_SHADES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  mcant_pkg::in_word_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mcant_pkg::out_word_t                 out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mcant_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mcant_pkg::DIM_W-1:0]          cfg_data_i
);
  import mcant_pkg::*;

  localparam int unsigned COL_TOP    = (GRID_COLS < SHADE_SPACE) ? GRID_COLS : SHADE_SPACE;
  localparam int unsigned ROW_TOP    = (GRID_ROWS < SHADE_SPACE) ? GRID_ROWS : SHADE_SPACE;
  localparam int unsigned GRID_DEPTH = GRID_ROWS * GRID_COLS;
  localparam int unsigned GRID_AW    = $clog2(GRID_DEPTH);
  localparam int unsigned SHADE_AW   = $clog2(NUM_SHADES);

  logic [DIM_W-1:0]      grid_width_q, grid_height_q;
  logic [DIM_W-1:0]      width_use, height_use;

  logic [POS_W-1:0]      pos_row_q, pos_row_d;
  logic [POS_W-1:0]      pos_col_q, pos_col_d;
  heading_e              facing_q, facing_d;
  logic                  halted_q, halted_d;
  logic [GEN_W-1:0]      gen_q, gen_d;
  logic [NUM_SHADES-1:0] rule_valid_q, rule_valid_d;
  logic                  step_b_q, step_b_d;
  logic                  step_c_q;
  logic                  rv_q, rv_d;

  logic                  in_acc;
  logic                  in_inside;
  logic                  shade_ok;

  logic                  grid_we, grid_re;
  logic [GRID_AW-1:0]    grid_waddr, pos_addr, cell_addr;
  logic [SHADE_W-1:0]    grid_wdata, grid_rdata;

  logic                  rule_we;
  logic [RULE_W-1:0]     rule_rdata;
  logic [SHADE_W-1:0]    repl;
  logic [TURN_W-1:0]     rt;
  logic [1:0]            face_sum;
  heading_e              new_face;
  logic [DIM_W-1:0]      nr, nc;
  logic                  move_ok, moved;

  logic                  push, pop;
  status_e               st;
  logic [SHADE_W-1:0]    shade_out;
  out_word_t             push_word;
  out_word_t             head_q, head_d, skid_q, skid_d;
  logic [1:0]            out_cnt_q, out_cnt_d;

  // grid dimensions in use
  always_comb begin
    width_use = grid_width_q;
    if (grid_width_q == '0) begin
      width_use = DIM_W'(1);
    end else if (grid_width_q > DIM_W'(COL_TOP)) begin
      width_use = DIM_W'(COL_TOP);
    end
    height_use = grid_height_q;
    if (grid_height_q == '0) begin
      height_use = DIM_W'(1);
    end else if (grid_height_q > DIM_W'(ROW_TOP)) begin
      height_use = DIM_W'(ROW_TOP);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DIM_W'(SHADE_SPACE);
      grid_height_q <= DIM_W'(SHADE_SPACE);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !step_b_q && !step_c_q && (out_cnt_q != 2'd2);
  assign in_acc     = in_valid_i && in_ready_o;

  assign in_inside = ({1'b0, in_data_i.row} < height_use) && ({1'b0, in_data_i.col} < width_use);
  assign shade_ok  = ({1'b0, in_data_i.shade} < DIM_W'(NUM_SHADES));

  assign pos_addr  = GRID_AW'(pos_row_q) * GRID_AW'(GRID_COLS) + GRID_AW'(pos_col_q);
  assign cell_addr = GRID_AW'(in_data_i.row) * GRID_AW'(GRID_COLS) + GRID_AW'(in_data_i.col);

  // grid store: read at step accept, written by a cell write or step commit
  assign grid_re    = in_acc && (in_data_i.cmd == CMD_STEP) && !halted_q;
  assign grid_we    = (in_acc && (in_data_i.cmd == CMD_WRITE_CELL) && in_inside) ||
                      (step_c_q && rv_q);
  assign grid_waddr = step_c_q ? pos_addr : cell_addr;
  assign grid_wdata = step_c_q ? repl : in_data_i.shade;

  mcant_ram #(
    .WIDTH (SHADE_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .re_i    (grid_re),
    .raddr_i (pos_addr),
    .rdata_o (grid_rdata)
  );

  assign rule_we = in_acc && (in_data_i.cmd == CMD_WRITE_RULE) && shade_ok &&
                   (in_data_i.turn != TURN_BAD);

  mcant_ram #(
    .WIDTH (RULE_W),
    .DEPTH (NUM_SHADES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (rule_we),
    .waddr_i (in_data_i.shade[SHADE_AW-1:0]),
    .wdata_i ({in_data_i.replacement, in_data_i.turn}),
    .re_i    (step_b_q),
    .raddr_i (grid_rdata[SHADE_AW-1:0]),
    .rdata_o (rule_rdata)
  );

  assign rv_d = ({1'b0, grid_rdata} < DIM_W'(NUM_SHADES)) &&
                rule_valid_q[grid_rdata[SHADE_AW-1:0]];

  // step commit
  assign repl     = rule_rdata[RULE_W-1:TURN_W];
  assign rt       = rule_rdata[TURN_W-1:0];
  assign face_sum = facing_q + rt + 2'd3;
  assign new_face = heading_e'(face_sum);

  always_comb begin
    nr      = {1'b0, pos_row_q};
    nc      = {1'b0, pos_col_q};
    move_ok = 1'b1;
    unique case (new_face)
      HEAD_NORTH: begin
        if (pos_row_q == '0) move_ok = 1'b0;
        else nr = nr - DIM_W'(1);
      end
      HEAD_EAST:  nc = nc + DIM_W'(1);
      HEAD_SOUTH: nr = nr + DIM_W'(1);
      HEAD_WEST: begin
        if (pos_col_q == '0) move_ok = 1'b0;
        else nc = nc - DIM_W'(1);
      end
      default: ;
    endcase
    moved = move_ok && (nr < height_use) && (nc < width_use);
  end

  always_comb begin
    pos_row_d    = pos_row_q;
    pos_col_d    = pos_col_q;
    facing_d     = facing_q;
    halted_d     = halted_q;
    gen_d        = gen_q;
    rule_valid_d = rule_valid_q;
    step_b_d     = 1'b0;
    push         = 1'b0;
    st           = ST_ACK;
    shade_out    = '0;
    if (step_c_q) begin
      push = 1'b1;
      if (!rv_q) begin
        st = ST_NO_RULE;
      end else begin
        facing_d  = new_face;
        shade_out = repl;
        if (moved) begin
          pos_row_d = nr[POS_W-1:0];
          pos_col_d = nc[POS_W-1:0];
          if (gen_q != {GEN_W{1'b1}}) gen_d = gen_q + GEN_W'(1);
          st = ST_MOVED;
        end else begin
          halted_d = 1'b1;
          st       = ST_BOUNDARY;
        end
      end
    end else if (in_acc) begin
      unique case (in_data_i.cmd)
        CMD_WRITE_RULE: begin
          push = 1'b1;
          if (rule_we) rule_valid_d[in_data_i.shade[SHADE_AW-1:0]] = 1'b1;
        end
        CMD_WRITE_CELL: begin
          push = 1'b1;
          if (!in_inside) st = ST_BOUNDARY;
        end
        CMD_PLACE: begin
          push = 1'b1;
          if (in_inside) begin
            pos_row_d = in_data_i.row;
            pos_col_d = in_data_i.col;
            facing_d  = in_data_i.heading;
            halted_d  = 1'b0;
          end else begin
            st = ST_BOUNDARY;
          end
        end
        CMD_STEP: begin
          if (halted_q) begin
            push = 1'b1;
            st   = ST_HALTED;
          end else begin
            step_b_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    push_word.status      = st;
    push_word.ant_row     = pos_row_d;
    push_word.ant_col     = pos_col_d;
    push_word.ant_heading = facing_d;
    push_word.new_shade   = shade_out;
    push_word.generation  = gen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_row_q    <= '0;
      pos_col_q    <= '0;
      facing_q     <= HEAD_NORTH;
      halted_q     <= 1'b0;
      gen_q        <= '0;
      rule_valid_q <= '0;
      step_b_q     <= 1'b0;
      step_c_q     <= 1'b0;
      rv_q         <= 1'b0;
    end else begin
      pos_row_q    <= pos_row_d;
      pos_col_q    <= pos_col_d;
      facing_q     <= facing_d;
      halted_q     <= halted_d;
      gen_q        <= gen_d;
      rule_valid_q <= rule_valid_d;
      step_b_q     <= step_b_d;
      step_c_q     <= step_b_q;
      if (step_b_q) rv_q <= rv_d;
    end
  end

  // two-word output buffer
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (out_cnt_q != 2'd0);
  assign out_data_o  = head_q;

  always_comb begin
    head_d = head_q;
    skid_d = skid_q;
    unique case ({push, pop})
      2'b10:   out_cnt_d = out_cnt_q + 2'd1;
      2'b01:   out_cnt_d = out_cnt_q - 2'd1;
      default: out_cnt_d = out_cnt_q;
    endcase
    if (pop && (out_cnt_q == 2'd2)) head_d = skid_q;
    if (push) begin
      if ((out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && pop)) head_d = push_word;
      else skid_d = push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

>>> hw/rtl/mcant_checker.sv
module mcant_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input mcant_pkg::in_word_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input mcant_pkg::out_word_t out_data_o
);
  import mcant_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.cmd != CMD_STEP) |=> out_valid_o)
    else $error("write or place gave no result word");

  a_step_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.cmd == CMD_STEP) |=> !in_ready_o || out_valid_o)
    else $error("live step did not block the next command");

  a_no_shade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == ST_ACK) || (out_data_o.status == ST_HALTED) ||
                    (out_data_o.status == ST_NO_RULE)) |-> (out_data_o.new_shade == '0))
    else $error("new shade reported without a cell write");

  a_moved_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_MOVED) |-> (out_data_o.generation != '0))
    else $error("move reported with zero generation");

endmodule

bind multicolor_ant_automaton_step_unit mcant_checker u_mcant_checker (.*);
